### design/ecq_pkg.sv
// Shared types and constants for the event queue with front slot and ring.
package ecq_pkg;

	// Action codes
	localparam logic [1:0] ACT_FIFO = 2'd0;
	localparam logic [1:0] ACT_LIFO = 2'd1;
	localparam logic [1:0] ACT_GET  = 2'd2;

	// Field and counter widths
	localparam int EVT_W  = 16;
	localparam int QLEN_W = 5;
	localparam int CNT_W  = QLEN_W + 1;
	localparam int MRG_W  = 8;

	// Ring sizing and queue_length reset value
	localparam int RING_DEPTH_DEF = 16;
	localparam int QLEN_RESET     = 16;

	// Configuration port
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;
	localparam int REG_IW   = APB_AW - 2;
	localparam logic [REG_IW-1:0] REG_QLEN = '0;

	// Command word
	typedef struct packed {
		logic [1:0]       action;
		logic [EVT_W-1:0] event_handle;
		logic             use_margin;
		logic [MRG_W-1:0] margin;
	} cmd_t;

	// Result word
	typedef struct packed {
		logic              accepted;
		logic              fault;
		logic              got_event;
		logic [EVT_W-1:0]  event_out;
		logic [QLEN_W-1:0] free_count;
		logic [QLEN_W-1:0] min_free;
		logic [QLEN_W-1:0] used_count;
		logic              is_empty;
	} res_t;

endpackage

### design/ecq_ring.sv
// Ring storage: one write port, one read port with registered read data.
module ecq_ring #(
	parameter int DEPTH = ecq_pkg::RING_DEPTH_DEF,
	parameter int AW    = 4,
	parameter int DW    = ecq_pkg::EVT_W
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/event_queue_front_slot_ring.sv
// Top level: event-handle queue with a front slot and a ring memory.
//
//  port group          dir  word      handshake
//  start/busy/cmd      in   cmd_t     taken when start & !busy
//  done/result         out  res_t     one-cycle strobe, no backpressure
//  psel..prdata        cfg  32 bit    APB write at psel&penable&pwrite
//
// For each command, the accept edge reads the ring at the tail
// index, the next cycle (busy high) uses that read data to update the state
// and the ring and loads the result word. done strobes in the cycle after,
// while the next command can already be taken. No forwarding is needed since
// busy holds off the next read until the write has landed.
// Reset clears the control state; the ring holds no reset value and needs no
// clearing pass. The receiver cannot stall.
module event_queue_front_slot_ring #(
	parameter int RING_DEPTH = ecq_pkg::RING_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// command channel
	input  logic                      start,
	output logic                      busy,
	input  ecq_pkg::cmd_t             cmd,
	// result channel
	output logic                      done,
	output ecq_pkg::res_t             result,
	// configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ecq_pkg::APB_AW-1:0] paddr,
	input  logic [ecq_pkg::APB_DW-1:0] pwdata,
	output logic [ecq_pkg::APB_DW-1:0] prdata,
	output logic                      pready
);

	localparam int IDX_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int QLEN_W  = ecq_pkg::QLEN_W;
	localparam int CNT_W   = ecq_pkg::CNT_W;
	localparam int EVT_W   = ecq_pkg::EVT_W;
	localparam int CMP_W   = ((IDX_W > QLEN_W) ? IDX_W : QLEN_W) + 1;
	localparam int QLEN_RST = (RING_DEPTH < ecq_pkg::QLEN_RESET) ?
		RING_DEPTH : ecq_pkg::QLEN_RESET;

	// queue state
	logic [QLEN_W-1:0] qlen_q;
	logic [EVT_W-1:0]  front_q;
	logic              front_valid_q;
	logic [IDX_W-1:0]  head_q, tail_q;
	logic [CNT_W-1:0]  free_q, low_q;

	// execute stage
	logic              busy_s1;
	ecq_pkg::cmd_t     cmd_s1;
	logic [EVT_W-1:0]  ring_rd;

	// result register
	logic              done_q;
	ecq_pkg::res_t     res_q;

	// next-state values
	logic [EVT_W-1:0]  front_n;
	logic              front_valid_n;
	logic [IDX_W-1:0]  head_n, tail_n;
	logic [CNT_W-1:0]  free_n, low_n, used_n;
	logic              ring_we;
	logic [IDX_W-1:0]  ring_wa;
	logic [EVT_W-1:0]  ring_wd;
	ecq_pkg::res_t     res_n;

	logic              cmd_take, cfg_wr, reg_hit;
	logic [QLEN_W-1:0] qlen_wr;
	logic [IDX_W-1:0]  qlen_last;
	logic [CMP_W-1:0]  tail_inc;
	logic              post_ok;

	assign cmd_take = start && !busy_s1;
	assign busy     = busy_s1;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign reg_hit  = (paddr[ecq_pkg::APB_AW-1:2] == ecq_pkg::REG_QLEN);

	// clamp written length to the ring depth
	always_comb begin
		qlen_wr = pwdata[QLEN_W-1:0];
		if ({3'b000, pwdata[QLEN_W-1:0]} > 8'(RING_DEPTH)) begin
			qlen_wr = QLEN_W'(RING_DEPTH);
		end
	end

	assign prdata = reg_hit ? {{(ecq_pkg::APB_DW-QLEN_W){1'b0}}, qlen_q} : '0;

	ecq_ring #(
		.DEPTH (RING_DEPTH),
		.AW    (IDX_W),
		.DW    (EVT_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (ring_we),
		.wr_addr (ring_wa),
		.wr_data (ring_wd),
		.rd_en   (cmd_take),
		.rd_addr (tail_q),
		.rd_data (ring_rd)
	);

	// execute: read-modify-write of the queue state
	always_comb begin
		front_n       = front_q;
		front_valid_n = front_valid_q;
		head_n        = head_q;
		tail_n        = tail_q;
		free_n        = free_q;
		low_n         = low_q;
		ring_we       = 1'b0;
		ring_wa       = head_q;
		ring_wd       = cmd_s1.event_handle;
		res_n         = '0;
		used_n        = '0;
		qlen_last     = IDX_W'(qlen_q - QLEN_W'(1));
		tail_inc      = CMP_W'(tail_q) + CMP_W'(1);
		post_ok       = cmd_s1.use_margin ?
			({2'b00, free_q} > cmd_s1.margin) : (free_q != '0);

		case (cmd_s1.action)
			ecq_pkg::ACT_FIFO: begin
				if (cmd_s1.event_handle == '0) begin
					res_n.fault = 1'b1;
				end else if (post_ok) begin
					res_n.accepted = 1'b1;
					free_n = free_q - CNT_W'(1);
					if (free_n < low_q) low_n = free_n;
					if (!front_valid_q) begin
						front_n       = cmd_s1.event_handle;
						front_valid_n = 1'b1;
					end else if (qlen_q != '0) begin
						ring_we = 1'b1;
						head_n  = (head_q == '0) ? qlen_last : head_q - IDX_W'(1);
					end
				end else if (!cmd_s1.use_margin) begin
					res_n.fault = 1'b1;
				end
			end
			ecq_pkg::ACT_LIFO: begin
				if (cmd_s1.event_handle == '0 || free_q == '0) begin
					res_n.fault = 1'b1;
				end else begin
					res_n.accepted = 1'b1;
					free_n = free_q - CNT_W'(1);
					if (free_n < low_q) low_n = free_n;
					if (front_valid_q && qlen_q != '0) begin
						tail_n  = (tail_inc >= CMP_W'(qlen_q)) ? '0 : tail_inc[IDX_W-1:0];
						ring_we = 1'b1;
						ring_wa = tail_n;
						ring_wd = front_q;
					end
					front_n       = cmd_s1.event_handle;
					front_valid_n = 1'b1;
				end
			end
			ecq_pkg::ACT_GET: begin
				if (front_valid_q) begin
					res_n.got_event = 1'b1;
					res_n.event_out = front_q;
					free_n = free_q + CNT_W'(1);
					if (free_n <= CNT_W'(qlen_q)) begin
						front_n = ring_rd;
						tail_n  = (tail_q == '0) ? qlen_last : tail_q - IDX_W'(1);
					end else begin
						front_n       = '0;
						front_valid_n = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase

		if (front_valid_n) used_n = CNT_W'(qlen_q) + CNT_W'(1) - free_n;
		res_n.free_count = free_n[QLEN_W-1:0];
		res_n.min_free   = low_n[QLEN_W-1:0];
		res_n.used_count = used_n[QLEN_W-1:0];
		res_n.is_empty   = !front_valid_n;
		if (!busy_s1) ring_we = 1'b0;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1       <= 1'b0;
			done_q        <= 1'b0;
			qlen_q        <= QLEN_W'(QLEN_RST);
			front_q       <= '0;
			front_valid_q <= 1'b0;
			head_q        <= '0;
			tail_q        <= '0;
			free_q        <= CNT_W'(QLEN_RST + 1);
			low_q         <= CNT_W'(QLEN_RST + 1);
		end else begin
			busy_s1 <= cmd_take;
			done_q  <= busy_s1;
			if (cfg_wr && reg_hit) begin
				qlen_q        <= qlen_wr;
				front_q       <= '0;
				front_valid_q <= 1'b0;
				head_q        <= '0;
				tail_q        <= '0;
				free_q        <= CNT_W'(qlen_wr) + CNT_W'(1);
				low_q         <= CNT_W'(qlen_wr) + CNT_W'(1);
			end else if (busy_s1) begin
				front_q       <= front_n;
				front_valid_q <= front_valid_n;
				head_q        <= head_n;
				tail_q        <= tail_n;
				free_q        <= free_n;
				low_q         <= low_n;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_take) cmd_s1 <= cmd;
		if (busy_s1)  res_q  <= res_n;
	end

	assign done   = done_q;
	assign result = res_q;

	// checks
	a_one_exec_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |=> !busy_s1)
		else $error("execute stage held for more than one cycle");
	a_done_follows_exec: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |=> done_q)
		else $error("no result after execute cycle");
	a_no_stray_done: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_s1 |=> !done_q)
		else $error("result without a command");
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= CNT_W'(qlen_q) + CNT_W'(1))
		else $error("free count above queue capacity");
	a_low_water: assert property (@(posedge clk) disable iff (!arst_n)
		low_q <= free_q)
		else $error("low-water mark above free count");
	a_empty_means_all_free: assert property (@(posedge clk) disable iff (!arst_n)
		!front_valid_q |-> (free_q == CNT_W'(qlen_q) + CNT_W'(1)))
		else $error("empty front slot with entries still held");

endmodule
